// ===== sv/mos_pkg.sv =====
package mos_pkg;

  localparam int MaxSamples = 32;
  localparam int SampleW    = 32;
  localparam int IdxW       = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
  localparam int CntW       = $clog2(MaxSamples + 1);
  localparam int CountOutW  = 6;
  localparam int OutDataW   = 40;  // median + count, padded to whole bytes

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [CntW-1:0]           count_t;
  typedef logic [IdxW-1:0]           idx_t;

  typedef enum logic [1:0] {
    StCollect,
    StPick,
    StLoad
  } state_e;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic clear;
  } chain_ctrl_t;

endpackage

// ===== sv/mos_cell.sv =====
module mos_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mos_pkg::chain_ctrl_t ctrl_i,
  input  mos_pkg::sample_t     sample_i,
  input  logic                 prev_gt_i,
  input  mos_pkg::sample_t     prev_val_i,
  input  logic                 prev_valid_i,
  output mos_pkg::sample_t     val_o,
  output logic                 valid_o,
  output logic                 gt_o
);

  mos_pkg::sample_t val_q, val_d;
  logic             valid_q, valid_d;

  // Empty cells count as +inf so the new sample lands in the first free slot
  assign gt_o = !valid_q || (val_q > sample_i);

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctrl_i.insert && gt_o) begin
      val_d   = prev_gt_i ? prev_val_i : sample_i;
      valid_d = valid_q | prev_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;

endmodule

// ===== sv/mos_chain.sv =====
module mos_chain (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mos_pkg::chain_ctrl_t ctrl_i,
  input  mos_pkg::sample_t     sample_i,
  input  mos_pkg::idx_t        lo_idx_i,
  input  mos_pkg::idx_t        hi_idx_i,
  output mos_pkg::sample_t     lo_val_o,
  output mos_pkg::sample_t     hi_val_o,
  output logic [mos_pkg::MaxSamples-1:0] valid_o
);

  mos_pkg::sample_t vals [mos_pkg::MaxSamples];
  logic [mos_pkg::MaxSamples-1:0] gt;

  for (genvar i = 0; i < mos_pkg::MaxSamples; i++) begin : g_cell
    if (i == 0) begin : g_head
      mos_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl_i),
        .sample_i     (sample_i),
        .prev_gt_i    (1'b0),
        .prev_val_i   (sample_i),
        .prev_valid_i (1'b1),
        .val_o        (vals[i]),
        .valid_o      (valid_o[i]),
        .gt_o         (gt[i])
      );
    end else begin : g_body
      mos_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl_i),
        .sample_i     (sample_i),
        .prev_gt_i    (gt[i-1]),
        .prev_val_i   (vals[i-1]),
        .prev_valid_i (valid_o[i-1]),
        .val_o        (vals[i]),
        .valid_o      (valid_o[i]),
        .gt_o         (gt[i])
      );
    end
  end

  // Read taps for the two middle entries
  always_comb begin
    lo_val_o = vals[0];
    hi_val_o = vals[0];
    for (int k = 0; k < mos_pkg::MaxSamples; k++) begin
      if (lo_idx_i == mos_pkg::IdxW'(k)) lo_val_o = vals[k];
      if (hi_idx_i == mos_pkg::IdxW'(k)) hi_val_o = vals[k];
    end
  end

endmodule

// ===== sv/median_of_samples.sv =====
// Streaming median of a set of signed Q16.16 samples. Samples enter on the
// slave side, one request per cycle while the row is collecting, and drop
// into a row of MaxSamples compare-and-shift cells that keep them in
// ascending order as they arrive. A request with tlast set closes the set:
// the slave side then stalls while the two middle entries are read out of
// the row (PICK) and averaged into the output register (LOAD); LOAD waits
// if the previous result has not yet been taken. The result (median, kept
// count, overflow flag) sits in the output register, so the next set
// streams in while it waits. For an even count the median is
// floor((a + b) / 2) of the middle pair, formed at 33 bits. Samples
// arriving with the row full are dropped and reported through
// m_axis_tuser; a dropped sample with tlast still closes the set.
module median_of_samples (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample
  input  logic        s_axis_tlast,   // last
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [mos_pkg::OutDataW-1:0] m_axis_tdata, // [31:0] median_value,
                                                     // [37:32] sample_count,
                                                     // [39:38] zero
  output logic        m_axis_tuser    // overflowed
);

  mos_pkg::state_e state_q, state_d;

  mos_pkg::count_t count_q, count_d;
  logic            drop_q, drop_d;

  // Captured middle pair and set summary
  mos_pkg::sample_t lo_q, hi_q;
  mos_pkg::count_t  hold_cnt_q;
  logic             hold_ovf_q;

  // Output register
  logic                         out_valid_q, out_valid_d;
  mos_pkg::sample_t             out_med_q;
  logic [mos_pkg::CountOutW-1:0] out_cnt_q;
  logic                         out_ovf_q;

  mos_pkg::chain_ctrl_t ctrl;
  mos_pkg::idx_t        lo_idx, hi_idx;
  mos_pkg::sample_t     lo_val, hi_val;
  logic [mos_pkg::MaxSamples-1:0] cell_valid;

  logic accept, full, out_free;
  logic [mos_pkg::SampleW:0] pair_sum;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign full     = (count_q >= mos_pkg::CntW'(mos_pkg::MaxSamples));
  assign out_free = !out_valid_q || m_axis_tready;

  // Middle indices: odd n reads s[n/2] twice, even n reads s[n/2-1], s[n/2]
  always_comb begin
    hi_idx = mos_pkg::IdxW'(count_q >> 1);
    lo_idx = count_q[0] ? hi_idx : mos_pkg::IdxW'(hi_idx - 1'b1);
  end

  mos_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (mos_pkg::sample_t'(s_axis_tdata)),
    .lo_idx_i (lo_idx),
    .hi_idx_i (hi_idx),
    .lo_val_o (lo_val),
    .hi_val_o (hi_val),
    .valid_o  (cell_valid)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mos_pkg::StCollect: if (accept && s_axis_tlast) state_d = mos_pkg::StPick;
      mos_pkg::StPick:    state_d = mos_pkg::StLoad;
      mos_pkg::StLoad:    if (out_free) state_d = mos_pkg::StCollect;
      default:            state_d = mos_pkg::StCollect;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    ctrl          = '0;
    count_d       = count_q;
    drop_d        = drop_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    unique case (state_q)
      mos_pkg::StCollect: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            ctrl.insert = 1'b1;
            count_d     = count_q + 1'b1;
          end
        end
      end
      mos_pkg::StPick: begin
        // middle pair is latched this cycle, so the row can be emptied
        ctrl.clear = 1'b1;
        count_d    = '0;
        drop_d     = 1'b0;
      end
      mos_pkg::StLoad: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign pair_sum = {lo_q[mos_pkg::SampleW-1], lo_q} + {hi_q[mos_pkg::SampleW-1], hi_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mos_pkg::StCollect;
      count_q     <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mos_pkg::StPick) begin
      lo_q       <= lo_val;
      hi_q       <= hi_val;
      hold_cnt_q <= count_q;
      hold_ovf_q <= drop_q;
    end
    if (state_q == mos_pkg::StLoad && out_free) begin
      // arithmetic shift of the 33-bit sum floors towards minus infinity
      out_med_q <= pair_sum[mos_pkg::SampleW:1];
      out_cnt_q <= mos_pkg::CountOutW'(hold_cnt_q);
      out_ovf_q <= hold_ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = mos_pkg::OutDataW'({out_cnt_q, out_med_q});
  assign m_axis_tuser  = out_ovf_q;

  // Occupied cells always form a contiguous run matching the kept count
  a_valid_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q) &&
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("cell occupancy disagrees with kept count");

  // Kept count never passes capacity
  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mos_pkg::CntW'(mos_pkg::MaxSamples))
    else $error("kept count beyond capacity");

  // A closing request leads through PICK, whose clear empties the row
  a_close_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |-> ##2 (cell_valid == '0))
    else $error("row not cleared after closing request");

  // An overflowed set always reports a full row
  a_ovf_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      out_cnt_q == mos_pkg::CountOutW'(mos_pkg::MaxSamples))
    else $error("overflow reported without a full row");

endmodule
